// ===== rtl/gacc_pkg.sv =====
package gacc_pkg;

  // Table size
  localparam int MAX_SOURCES = 16;
  localparam int SRC_AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int SRC_CW = $clog2(MAX_SOURCES + 1);

  // Field widths
  localparam int POS_W  = 24;
  localparam int MASS_W = 24;
  localparam int ACC_OUT_W = 32;

  // Datapath widths
  localparam int DIFF_W = POS_W + 1;          // source minus body, signed
  localparam int MAG_W  = POS_W + 1;          // magnitude of the difference
  localparam int PROD_W = 2 * MAG_W;          // shared multiplier product
  localparam int DSQ_W  = PROD_W;             // dx^2 + dy^2 stays below 2^50
  localparam int DVD_W  = PROD_W + 8;         // mag * mass * 256
  // The distance threshold bounds every quotient below mass * 256 / 2560 < 2^21
  localparam int QUO_W  = 21;
  localparam int ACC_W  = 40;                 // holds 256 terms of QUO_W bits plus sign
  localparam int ENT_W  = 2 * POS_W + MASS_W; // one table entry

  // 100 units squared in Q.16
  localparam logic [DSQ_W-1:0] DSQ_THRESH = DSQ_W'(100) << 16;

  // Saturation limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(64'sd2147483648);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

endpackage

// ===== rtl/gacc_ram.sv =====
module gacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/gacc_div.sv =====
module gacc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gacc_pkg::DVD_W-1:0]    dividend_i,
  input  logic [gacc_pkg::DSQ_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [gacc_pkg::QUO_W-1:0]    quot_o
);

  localparam int SH_W  = gacc_pkg::DSQ_W + gacc_pkg::QUO_W - 1;
  localparam int CNT_W = (gacc_pkg::QUO_W > 1) ? $clog2(gacc_pkg::QUO_W) : 1;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [gacc_pkg::DVD_W-1:0]  rem_q, rem_d;
  logic [SH_W-1:0]             dsh_q, dsh_d;
  logic [gacc_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic                        fits;

  // Restoring division, one quotient bit per cycle, MSB first
  assign fits = SH_W'(rem_q) >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(gacc_pkg::QUO_W - 1);
      rem_d  = dividend_i;
      dsh_d  = SH_W'(divisor_i) << (gacc_pkg::QUO_W - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q[gacc_pkg::DVD_W-1:0];
      end
      quo_d = {quo_q[gacc_pkg::QUO_W-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/gravity_acceleration_sum.sv =====
// Gravity source table with direct-sum acceleration query. Clear, add and unused-kind
// transactions give their result in the cycle after they are taken; a query walks
// the stored sources one at a time through a single shared 25x25 multiplier and a
// radix-2 divider that produces 21 quotient bits. Only a source that lies beyond
// the distance threshold is counted; a source inside it is dropped right after its
// squared distance is checked. A query on an empty table answers in the cycle after
// it is taken, like the other kinds. A counted source costs four multiplier passes,
// one table read and two divisions. busy is high from the cycle after a query on a
// nonempty table is taken until its result is shown. Every transaction gives exactly
// one result, shown for one cycle with done_o; the receiver cannot stall it, so it
// must take results as they come.
module gravity_acceleration_sum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind_i,
  input  logic signed [gacc_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [gacc_pkg::POS_W-1:0]   pos_y_i,
  input  logic [gacc_pkg::MASS_W-1:0]         mass_i,
  output logic                                done_o,
  output logic signed [gacc_pkg::ACC_OUT_W-1:0] accel_x_o,
  output logic signed [gacc_pkg::ACC_OUT_W-1:0] accel_y_o,
  output logic                                table_full_o
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_READ  = 14'b00000000000010,
    ST_LOAD  = 14'b00000000000100,
    ST_SQX   = 14'b00000000001000,
    ST_SQY   = 14'b00000000010000,
    ST_CHK   = 14'b00000000100000,
    ST_MULX  = 14'b00000001000000,
    ST_DSTX  = 14'b00000010000000,
    ST_WAITX = 14'b00000100000000,
    ST_MULY  = 14'b00001000000000,
    ST_DSTY  = 14'b00010000000000,
    ST_WAITY = 14'b00100000000000,
    ST_NEXT  = 14'b01000000000000,
    ST_FIN   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic [gacc_pkg::SRC_CW-1:0]        count_q, count_d;
  logic [gacc_pkg::SRC_CW-1:0]        idx_q, idx_d;
  logic signed [gacc_pkg::POS_W-1:0]  bx_q, by_q;
  logic [gacc_pkg::MAG_W-1:0]         mx_q, my_q;
  logic                               nx_q, ny_q;
  logic [gacc_pkg::MASS_W-1:0]        m_q;
  logic [gacc_pkg::DSQ_W-1:0]         dsq_q;
  logic [gacc_pkg::PROD_W-1:0]        num_q;
  logic signed [gacc_pkg::ACC_W-1:0]  ax_q, ay_q;
  logic                               done_q, done_d;
  logic signed [gacc_pkg::ACC_OUT_W-1:0] out_x_q, out_y_q;
  logic                               full_q;

  logic                               accept;
  logic                               tbl_full;
  logic                               ram_we;
  logic [gacc_pkg::ENT_W-1:0]         ram_rdata;
  logic signed [gacc_pkg::POS_W-1:0]  src_x, src_y;
  logic signed [gacc_pkg::DIFF_W-1:0] dx, dy;
  logic [gacc_pkg::MAG_W-1:0]         mul_a, mul_b;
  logic [gacc_pkg::PROD_W-1:0]        mul_p;
  logic                               div_start, div_done;
  logic [gacc_pkg::QUO_W-1:0]         div_quot;
  logic signed [gacc_pkg::ACC_W-1:0]  term;

  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q != ST_IDLE);
  assign tbl_full = (count_q == gacc_pkg::SRC_CW'(gacc_pkg::MAX_SOURCES));
  assign ram_we   = accept && (kind_i == gacc_pkg::KIND_ADD) && !tbl_full;

  // Source table
  gacc_ram #(
    .WIDTH (gacc_pkg::ENT_W),
    .DEPTH (gacc_pkg::MAX_SOURCES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[gacc_pkg::SRC_AW-1:0]),
    .wdata_i ({pos_x_i, pos_y_i, mass_i}),
    .raddr_i (idx_q[gacc_pkg::SRC_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign src_x = ram_rdata[gacc_pkg::ENT_W-1 -: gacc_pkg::POS_W];
  assign src_y = ram_rdata[gacc_pkg::MASS_W +: gacc_pkg::POS_W];
  assign dx    = gacc_pkg::DIFF_W'(src_x) - gacc_pkg::DIFF_W'(bx_q);
  assign dy    = gacc_pkg::DIFF_W'(src_y) - gacc_pkg::DIFF_W'(by_q);

  // Shared multiplier: squares first, then magnitude times mass
  always_comb begin
    case (state_q)
      ST_SQX:  begin mul_a = mx_q; mul_b = mx_q; end
      ST_SQY:  begin mul_a = my_q; mul_b = my_q; end
      ST_MULX: begin mul_a = mx_q; mul_b = gacc_pkg::MAG_W'(m_q); end
      ST_MULY: begin mul_a = my_q; mul_b = gacc_pkg::MAG_W'(m_q); end
      default: begin mul_a = '0;   mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Shared divider
  assign div_start = (state_q == ST_DSTX) || (state_q == ST_DSTY);

  gacc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({num_q, 8'b0}),
    .divisor_i  (dsq_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Signed term from the quotient
  always_comb begin
    term = gacc_pkg::ACC_W'(div_quot);
    if ((state_q == ST_WAITX) ? nx_q : ny_q) begin
      term = -term;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            gacc_pkg::KIND_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            gacc_pkg::KIND_ADD: begin
              if (!tbl_full) begin
                count_d = count_q + 1'b1;
              end
              done_d = 1'b1;
            end
            gacc_pkg::KIND_QUERY: begin
              idx_d = '0;
              if (count_q == '0) begin
                done_d = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_CHK;
      ST_CHK:   state_d = (dsq_q > gacc_pkg::DSQ_THRESH) ? ST_MULX : ST_NEXT;
      ST_MULX:  state_d = ST_DSTX;
      ST_DSTX:  state_d = ST_WAITX;
      ST_WAITX: if (div_done) state_d = ST_MULY;
      ST_MULY:  state_d = ST_DSTY;
      ST_DSTY:  state_d = ST_WAITY;
      ST_WAITY: if (div_done) state_d = ST_NEXT;
      ST_NEXT: begin
        if ((idx_q + 1'b1) < count_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_READ;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bx_q <= pos_x_i;
      by_q <= pos_y_i;
      ax_q <= '0;
      ay_q <= '0;
    end
    if (state_q == ST_LOAD) begin
      nx_q <= dx[gacc_pkg::DIFF_W-1];
      ny_q <= dy[gacc_pkg::DIFF_W-1];
      mx_q <= dx[gacc_pkg::DIFF_W-1] ? gacc_pkg::MAG_W'(-dx) : gacc_pkg::MAG_W'(dx);
      my_q <= dy[gacc_pkg::DIFF_W-1] ? gacc_pkg::MAG_W'(-dy) : gacc_pkg::MAG_W'(dy);
      m_q  <= ram_rdata[gacc_pkg::MASS_W-1:0];
    end
    if (state_q == ST_SQX) begin
      dsq_q <= mul_p;
    end
    if (state_q == ST_SQY) begin
      dsq_q <= dsq_q + mul_p;
    end
    if ((state_q == ST_MULX) || (state_q == ST_MULY)) begin
      num_q <= mul_p;
    end
    if ((state_q == ST_WAITX) && div_done) begin
      ax_q <= ax_q + term;
    end
    if ((state_q == ST_WAITY) && div_done) begin
      ay_q <= ay_q + term;
    end
  end

  // Result registers, with saturation of the sums
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_x_q <= '0;
      out_y_q <= '0;
      full_q  <= (kind_i == gacc_pkg::KIND_ADD) && tbl_full;
    end else if (state_q == ST_FIN) begin
      full_q <= 1'b0;
      if (ax_q > gacc_pkg::ACC_MAX) begin
        out_x_q <= gacc_pkg::ACC_OUT_W'(gacc_pkg::ACC_MAX);
      end else if (ax_q < gacc_pkg::ACC_MIN) begin
        out_x_q <= gacc_pkg::ACC_OUT_W'(gacc_pkg::ACC_MIN);
      end else begin
        out_x_q <= gacc_pkg::ACC_OUT_W'(ax_q);
      end
      if (ay_q > gacc_pkg::ACC_MAX) begin
        out_y_q <= gacc_pkg::ACC_OUT_W'(gacc_pkg::ACC_MAX);
      end else if (ay_q < gacc_pkg::ACC_MIN) begin
        out_y_q <= gacc_pkg::ACC_OUT_W'(gacc_pkg::ACC_MIN);
      end else begin
        out_y_q <= gacc_pkg::ACC_OUT_W'(ay_q);
      end
    end
  end

  assign done_o       = done_q;
  assign accel_x_o    = out_x_q;
  assign accel_y_o    = out_y_q;
  assign table_full_o = full_q;

endmodule

// ===== rtl/gacc_checker.sv =====
module gacc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  start,
  input logic                                  busy,
  input logic [1:0]                            kind_i,
  input logic                                  done_o,
  input logic signed [gacc_pkg::ACC_OUT_W-1:0] accel_x_o,
  input logic signed [gacc_pkg::ACC_OUT_W-1:0] accel_y_o,
  input logic                                  table_full_o
);

  // Full flag never comes with a nonzero acceleration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> (accel_x_o == '0) && (accel_y_o == '0))
    else $error("table_full with nonzero acceleration");

  // Non-query transactions give their result in the next cycle, with busy low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i != gacc_pkg::KIND_QUERY) |=> done_o && !busy)
    else $error("non-query transaction did not complete in one cycle");

  // A clear gives an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == gacc_pkg::KIND_CLEAR)
    |=> !table_full_o && (accel_x_o == '0) && (accel_y_o == '0))
    else $error("clear result not zero");

  // A query either runs or answers an empty table with zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == gacc_pkg::KIND_QUERY)
    |=> busy || (done_o && (accel_x_o == '0) && (accel_y_o == '0)))
    else $error("query neither started nor returned an empty result");

  // No result strobe while the query is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && $past(busy) |-> !done_o)
    else $error("result strobe during a running query");

endmodule

bind gravity_acceleration_sum gacc_checker u_gacc_checker (.*);
